FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hw/rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and codes of the first-fit rover allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int REQ_W     = 17;
    localparam int OFF_W     = 16;
    localparam int STAT_W    = 2;
    localparam int BYTES_W   = 17;
    localparam int CFG_W     = 17;
    localparam int OP_W      = 5;

    localparam logic [CFG_W-1:0] MIN_FRAG_RST = 17'd64;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPTR = 2'd3;

    localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 5'd3;
    localparam logic [OP_W-1:0] OP_A_RD0 = 5'd4;
    localparam logic [OP_W-1:0] OP_A_ST  = 5'd5;
    localparam logic [OP_W-1:0] OP_A_CHK = 5'd6;
    localparam logic [OP_W-1:0] OP_A_SPL = 5'd7;
    localparam logic [OP_W-1:0] OP_A_LNK = 5'd8;
    localparam logic [OP_W-1:0] OP_A_USE = 5'd9;
    localparam logic [OP_W-1:0] OP_R_ADR = 5'd10;
    localparam logic [OP_W-1:0] OP_R_CHK = 5'd11;
    localparam logic [OP_W-1:0] OP_R_P1  = 5'd12;
    localparam logic [OP_W-1:0] OP_R_P2  = 5'd13;
    localparam logic [OP_W-1:0] OP_R_P3  = 5'd14;
    localparam logic [OP_W-1:0] OP_R_N0  = 5'd15;
    localparam logic [OP_W-1:0] OP_R_N1  = 5'd16;
    localparam logic [OP_W-1:0] OP_R_N2  = 5'd17;
    localparam logic [OP_W-1:0] OP_DONE  = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_release;
        logic addr_bad;
        logic rd_start;
        logic rd_in_use;
        logic fit;
        logic scan_last;
        logic split;
        logic g_nonzero;
        logic nx_in_pool;
        logic out_busy;
    } t_sts;

endpackage

FILE: hw/rtl/ffra_if.sv
// ----------------------------------------------------------------------------
// ffra_if
// Request and response channels of the allocator.
// ----------------------------------------------------------------------------
interface ffra_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [ffra_pkg::REQ_W-1:0] request_bytes;
    logic [ffra_pkg::OFF_W-1:0] release_offset;

    modport source (output valid, req_type, request_bytes, release_offset, input ready);
    modport sink   (input valid, req_type, request_bytes, release_offset, output ready);
endinterface

interface ffra_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ffra_pkg::OFF_W-1:0]   payload_offset;
    logic [ffra_pkg::STAT_W-1:0]  status;
    logic [ffra_pkg::BYTES_W-1:0] used_bytes;
    logic [ffra_pkg::BYTES_W-1:0] available_bytes;

    modport source (output valid, payload_offset, status, used_bytes, available_bytes,
                    input ready);
    modport sink   (input valid, payload_offset, status, used_bytes, available_bytes,
                    output ready);
endinterface

FILE: hw/rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: steps the datapath through divide, scan, split and merge.
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ffra_pkg::t_sts i_sts,
    output ffra_pkg::t_cmd o_cmd
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DIV   = 5'd2;
    localparam logic [4:0] S_A_RD0 = 5'd3;
    localparam logic [4:0] S_A_ST  = 5'd4;
    localparam logic [4:0] S_A_CHK = 5'd5;
    localparam logic [4:0] S_A_SPL = 5'd6;
    localparam logic [4:0] S_A_LNK = 5'd7;
    localparam logic [4:0] S_A_USE = 5'd8;
    localparam logic [4:0] S_R_ADR = 5'd9;
    localparam logic [4:0] S_R_CHK = 5'd10;
    localparam logic [4:0] S_R_P1  = 5'd11;
    localparam logic [4:0] S_R_P2  = 5'd12;
    localparam logic [4:0] S_R_P3  = 5'd13;
    localparam logic [4:0] S_R_N0  = 5'd14;
    localparam logic [4:0] S_R_N1  = 5'd15;
    localparam logic [4:0] S_R_N2  = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       take;

    assign o_in_ready = (r_state == S_IDLE);
    assign take       = o_in_ready && i_in_valid;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = ffra_pkg::OP_NOP;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = ffra_pkg::OP_CLEAR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take) begin
                    o_cmd.op = ffra_pkg::OP_LOAD;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = ffra_pkg::OP_DIV;
                n_state  = i_sts.is_release ? S_R_ADR : S_A_RD0;
            end
            S_A_RD0: begin
                o_cmd.op = ffra_pkg::OP_A_RD0;
                n_state  = S_A_ST;
            end
            S_A_ST: begin
                o_cmd.op = ffra_pkg::OP_A_ST;
                n_state  = S_A_CHK;
            end
            S_A_CHK: begin
                o_cmd.op = ffra_pkg::OP_A_CHK;
                if (i_sts.fit) n_state = S_A_SPL;
                else if (i_sts.scan_last) n_state = S_DONE;
            end
            S_A_SPL: begin
                o_cmd.op = ffra_pkg::OP_A_SPL;
                n_state  = i_sts.split ? S_A_LNK : S_A_USE;
            end
            S_A_LNK: begin
                o_cmd.op = ffra_pkg::OP_A_LNK;
                n_state  = S_A_USE;
            end
            S_A_USE: begin
                o_cmd.op = ffra_pkg::OP_A_USE;
                n_state  = S_DONE;
            end
            S_R_ADR: begin
                o_cmd.op = ffra_pkg::OP_R_ADR;
                n_state  = i_sts.addr_bad ? S_DONE : S_R_CHK;
            end
            S_R_CHK: begin
                o_cmd.op = ffra_pkg::OP_R_CHK;
                if (!i_sts.rd_start || !i_sts.rd_in_use) n_state = S_DONE;
                else n_state = i_sts.g_nonzero ? S_R_P1 : S_R_N0;
            end
            S_R_P1: begin
                o_cmd.op = ffra_pkg::OP_R_P1;
                n_state  = S_R_P2;
            end
            S_R_P2: begin
                o_cmd.op = ffra_pkg::OP_R_P2;
                n_state  = i_sts.rd_in_use ? S_R_N0 : S_R_P3;
            end
            S_R_P3: begin
                o_cmd.op = ffra_pkg::OP_R_P3;
                n_state  = S_R_N0;
            end
            S_R_N0: begin
                o_cmd.op = ffra_pkg::OP_R_N0;
                n_state  = i_sts.nx_in_pool ? S_R_N1 : S_DONE;
            end
            S_R_N1: begin
                o_cmd.op = ffra_pkg::OP_R_N1;
                n_state  = i_sts.rd_in_use ? S_DONE : S_R_N2;
            end
            S_R_N2: begin
                o_cmd.op = ffra_pkg::OP_R_N2;
                n_state  = S_DONE;
            end
            S_DONE: begin
                o_cmd.op = ffra_pkg::OP_DONE;
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/ffra_dpath.sv
// ----------------------------------------------------------------------------
// ffra_dpath
// Block table, back-link table, size rounding, pool counters and result
// register.
// ----------------------------------------------------------------------------
module ffra_dpath #(
    parameter int POOL_BYTES   = 65536,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 32,
    parameter int GUARD_BYTES  = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ffra_pkg::t_cmd               i_cmd,
    output ffra_pkg::t_sts               o_sts,
    input  logic                         i_cfg_we,
    input  logic [ffra_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_req_type,
    input  logic [ffra_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [ffra_pkg::OFF_W-1:0]   i_release_offset,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output logic [ffra_pkg::OFF_W-1:0]   o_payload_offset,
    output logic [ffra_pkg::STAT_W-1:0]  o_status,
    output logic [ffra_pkg::BYTES_W-1:0] o_used_bytes,
    output logic [ffra_pkg::BYTES_W-1:0] o_available_bytes
);

    localparam int NGRAN = POOL_BYTES / ALIGN_BYTES;
    localparam int SPAN  = NGRAN * ALIGN_BYTES;
    localparam int GW    = $clog2(NGRAN);
    localparam int CW    = $clog2(NGRAN + 1);
    localparam int AW    = $clog2(ALIGN_BYTES + 1);
    localparam int SH    = $clog2(ALIGN_BYTES);
    localparam int DW    = ffra_pkg::REQ_W + 1;   // request plus rounding addend
    localparam int XW    = ((CW > DW) ? CW : DW) + 1;
    localparam int PW    = CW + AW;
    localparam int EW    = ((PW > ffra_pkg::CFG_W) ? PW : ffra_pkg::CFG_W) + 1;
    localparam int YW    = PW + 8;
    localparam int WW    = CW + 2;   // {start, in_use, granule count}
    localparam int ADD_A = HEADER_BYTES + GUARD_BYTES + ALIGN_BYTES - 1;

    // memories
    logic [WW-1:0] r_mem  [NGRAN];
    logic [GW-1:0] r_prev [NGRAN];
    logic [WW-1:0] r_rd;
    logic [GW-1:0] r_prd;

    logic          mem_we;
    logic [GW-1:0] mem_wa;
    logic [WW-1:0] mem_wd;
    logic [GW-1:0] mem_ra;
    logic          prev_we;
    logic [GW-1:0] prev_wa;
    logic [GW-1:0] prev_wd;
    logic [GW-1:0] prev_ra;

    // state
    logic [GW-1:0]                 r_clr;
    logic [DW-1:0]                 r_num;
    logic [DW-1:0]                 r_dvd;
    logic                          r_misalign;
    logic                          r_type;
    logic                          r_off_lo;
    logic [DW-1:0]                 r_need;
    logic [GW-1:0]                 r_g;
    logic [CW-1:0]                 r_cnt;
    logic [GW-1:0]                 r_p;
    logic [CW:0]                   r_nx;
    logic [GW-1:0]                 r_n;
    logic [GW-1:0]                 r_rover;
    logic [CW-1:0]                 r_used;
    logic [ffra_pkg::CFG_W-1:0]    r_minfrag;
    logic [ffra_pkg::STAT_W-1:0]   r_status;
    logic [ffra_pkg::OFF_W-1:0]    r_payload;
    logic                          r_out_valid;
    logic [ffra_pkg::OFF_W-1:0]    r_out_payload;
    logic [ffra_pkg::STAT_W-1:0]   r_out_status;
    logic [ffra_pkg::BYTES_W-1:0]  r_out_used;
    logic [ffra_pkg::BYTES_W-1:0]  r_out_avail;

    // decoded read word and derived values
    logic          rd_start;
    logic          rd_use;
    logic [CW-1:0] rd_cnt;
    logic [CW:0]   g_plus_rd;
    logic [GW-1:0] g_wrap;
    logic [CW:0]   g_plus_cnt;
    logic [GW-1:0] cnt_wrap;
    logic [CW:0]   p_plus_cnt;
    logic [CW-1:0] extra;
    logic [XW-1:0] t_sum;
    logic [GW-1:0] t_g;
    logic [XW-1:0] q_ext;
    logic [CW-1:0] sum_cnt;
    logic          split;
    logic          addr_bad;
    logic          out_busy;
    logic          out_load;
    logic [PW-1:0] used_b;
    logic [YW-1:0] pay_b;

    assign rd_start   = r_rd[CW+1];
    assign rd_use     = r_rd[CW];
    assign rd_cnt     = r_rd[CW-1:0];
    assign g_plus_rd  = (CW+1)'(r_g) + (CW+1)'(rd_cnt);
    assign g_wrap     = (g_plus_rd >= (CW+1)'(NGRAN)) ? '0 : g_plus_rd[GW-1:0];
    assign g_plus_cnt = (CW+1)'(r_g) + (CW+1)'(r_cnt);
    assign cnt_wrap   = (g_plus_cnt >= (CW+1)'(NGRAN)) ? '0 : g_plus_cnt[GW-1:0];
    assign p_plus_cnt = (CW+1)'(r_p) + (CW+1)'(r_cnt);
    assign extra      = r_cnt - CW'(r_need);
    assign t_sum      = XW'(r_g) + XW'(r_need);
    assign t_g        = t_sum[GW-1:0];
    assign q_ext      = XW'(r_dvd);
    assign sum_cnt    = rd_cnt + r_cnt;
    assign split      = (EW'(extra) * EW'(ALIGN_BYTES)) > EW'(r_minfrag);
    assign addr_bad   = r_off_lo || r_misalign || (q_ext >= XW'(NGRAN));
    assign out_busy   = r_out_valid && !i_rsp_ready;
    assign out_load   = (i_cmd.op == ffra_pkg::OP_DONE) && !out_busy;
    assign used_b     = PW'(r_used) * PW'(ALIGN_BYTES);
    assign pay_b      = YW'(r_g) * YW'(ALIGN_BYTES) + YW'(HEADER_BYTES);

    always_comb begin
        o_sts.clr_last   = (r_clr == GW'(NGRAN - 1));
        o_sts.is_release = (r_type == ffra_pkg::REQ_RELEASE);
        o_sts.addr_bad   = addr_bad;
        o_sts.rd_start   = rd_start;
        o_sts.rd_in_use  = rd_use;
        o_sts.fit        = !rd_use && (XW'(rd_cnt) >= XW'(r_need));
        o_sts.scan_last  = (r_n == GW'(NGRAN - 1));
        o_sts.split      = split;
        o_sts.g_nonzero  = (r_g != '0);
        o_sts.nx_in_pool = (g_plus_cnt < (CW+1)'(NGRAN));
        o_sts.out_busy   = out_busy;
    end

    // memory port steering
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_g;
        mem_wd  = '0;
        mem_ra  = r_g;
        prev_we = 1'b0;
        prev_wa = r_g;
        prev_wd = r_g;
        prev_ra = r_g;
        case (i_cmd.op)
            ffra_pkg::OP_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = (r_clr == '0) ? {2'b10, CW'(NGRAN)} : '0;
            end
            ffra_pkg::OP_A_RD0: mem_ra = r_rover;
            ffra_pkg::OP_A_ST:  mem_ra = rd_start ? r_g : '0;
            ffra_pkg::OP_A_CHK: mem_ra = g_wrap;
            ffra_pkg::OP_A_SPL: begin
                if (split) begin
                    mem_we  = 1'b1;
                    mem_wa  = t_g;
                    mem_wd  = {2'b10, extra};
                    prev_we = 1'b1;
                    prev_wa = t_g;
                    prev_wd = r_g;
                end
            end
            ffra_pkg::OP_A_LNK: begin
                // r_cnt already holds the trimmed size, so t is r_g + r_cnt
                if (r_nx < (CW+1)'(NGRAN)) begin
                    prev_we = 1'b1;
                    prev_wa = r_nx[GW-1:0];
                    prev_wd = g_plus_cnt[GW-1:0];
                end
            end
            ffra_pkg::OP_A_USE: begin
                mem_we = 1'b1;
                mem_wd = {2'b11, r_cnt};
            end
            ffra_pkg::OP_R_ADR: mem_ra = q_ext[GW-1:0];
            ffra_pkg::OP_R_CHK: begin
                if (rd_start && rd_use) begin
                    mem_we = 1'b1;
                    mem_wd = {2'b10, rd_cnt};
                end
            end
            ffra_pkg::OP_R_P1: mem_ra = r_prd;
            ffra_pkg::OP_R_P2: begin
                if (!rd_use) begin
                    mem_we = 1'b1;
                    mem_wa = r_p;
                    mem_wd = {2'b10, sum_cnt};
                end
            end
            ffra_pkg::OP_R_P3: begin
                mem_we = 1'b1;
                if (p_plus_cnt < (CW+1)'(NGRAN)) begin
                    prev_we = 1'b1;
                    prev_wa = p_plus_cnt[GW-1:0];
                    prev_wd = r_p;
                end
            end
            ffra_pkg::OP_R_N0: mem_ra = g_plus_cnt[GW-1:0];
            ffra_pkg::OP_R_N1: begin
                if (!rd_use) begin
                    mem_we = 1'b1;
                    mem_wd = {2'b10, sum_cnt};
                end
            end
            ffra_pkg::OP_R_N2: begin
                mem_we = 1'b1;
                mem_wa = r_nx[GW-1:0];
                if (g_plus_cnt < (CW+1)'(NGRAN)) begin
                    prev_we = 1'b1;
                    prev_wa = g_plus_cnt[GW-1:0];
                    prev_wd = r_g;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
        if (prev_we) r_prev[prev_wa] <= prev_wd;
        r_prd <= r_prev[prev_ra];
    end

    // payload-side registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ffra_pkg::OP_LOAD: begin
                r_type    <= i_req_type;
                r_off_lo  <= (i_release_offset < ffra_pkg::OFF_W'(HEADER_BYTES));
                r_status  <= ffra_pkg::ST_OK;
                r_payload <= '0;
                if (i_req_type == ffra_pkg::REQ_ALLOC) begin
                    r_num <= DW'(i_request_bytes) + DW'(ADD_A);
                end else begin
                    r_num <= DW'(i_release_offset - ffra_pkg::OFF_W'(HEADER_BYTES));
                end
            end
            ffra_pkg::OP_DIV: begin
                // alignment is a power of two: quotient by shift, remainder by mask
                r_dvd      <= r_num >> SH;
                r_misalign <= (r_num[SH-1:0] != '0);
            end
            ffra_pkg::OP_A_RD0: begin
                r_g    <= r_rover;
                r_need <= r_dvd;
                r_n    <= '0;
            end
            ffra_pkg::OP_A_ST: r_g <= rd_start ? r_g : '0;
            ffra_pkg::OP_A_CHK: begin
                if (o_sts.fit) begin
                    r_cnt <= rd_cnt;
                end else if (o_sts.scan_last) begin
                    r_status <= ffra_pkg::ST_NOFIT;
                end else begin
                    r_g <= g_wrap;
                    r_n <= r_n + 1'b1;
                end
            end
            ffra_pkg::OP_A_SPL: begin
                r_nx <= g_plus_cnt;
                if (split) r_cnt <= CW'(r_need);
            end
            ffra_pkg::OP_A_USE: r_payload <= ffra_pkg::OFF_W'(pay_b);
            ffra_pkg::OP_R_ADR: begin
                if (addr_bad) r_status <= ffra_pkg::ST_BADPTR;
                else r_g <= q_ext[GW-1:0];
            end
            ffra_pkg::OP_R_CHK: begin
                if (!rd_start) r_status <= ffra_pkg::ST_BADPTR;
                else if (!rd_use) r_status <= ffra_pkg::ST_FREE;
                else r_cnt <= rd_cnt;
            end
            ffra_pkg::OP_R_P1: r_p <= r_prd;
            ffra_pkg::OP_R_P2: begin
                if (!rd_use) r_cnt <= sum_cnt;
            end
            ffra_pkg::OP_R_P3: r_g <= r_p;
            ffra_pkg::OP_R_N0: r_nx <= g_plus_cnt;
            ffra_pkg::OP_R_N1: begin
                if (!rd_use) r_cnt <= sum_cnt;
            end
            default: begin
                r_g <= r_g;
            end
        endcase
        if (out_load) begin
            r_out_payload <= r_payload;
            r_out_status  <= r_status;
            r_out_used    <= ffra_pkg::BYTES_W'(used_b);
            r_out_avail   <= ffra_pkg::BYTES_W'(PW'(SPAN) - used_b);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_rover     <= '0;
            r_used      <= '0;
            r_minfrag   <= ffra_pkg::MIN_FRAG_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == ffra_pkg::OP_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) r_minfrag <= i_cfg_wdata;
            if (i_cmd.op == ffra_pkg::OP_A_USE) begin
                r_rover <= cnt_wrap;
                r_used  <= r_used + r_cnt;
            end
            if (i_cmd.op == ffra_pkg::OP_R_CHK && rd_start && rd_use) begin
                r_used <= r_used - rd_cnt;
            end
            if (i_cmd.op == ffra_pkg::OP_R_N0) r_rover <= r_g;
            if (out_load) r_out_valid <= 1'b1;
            else if (i_rsp_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_rsp_valid       = r_out_valid;
    assign o_payload_offset  = r_out_payload;
    assign o_status          = r_out_status;
    assign o_used_bytes      = r_out_used;
    assign o_available_bytes = r_out_avail;

endmodule

FILE: hw/rtl/first_fit_rover_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_rover_allocator
// First-fit pool allocator with a rover and coalescing of free neighbors.
// ----------------------------------------------------------------------------
// After reset the block table is cleared one granule per cycle, so the request
// channel stays not-ready until all POOL_BYTES/ALIGN_BYTES entries are clear;
// min_fragment_bytes writes are taken throughout. ALIGN_BYTES must be a power
// of two. One item is worked at a time. An allocate divides the size, reads the
// block at the rover, scans from there with one read of the block table per
// block visited, then on a fit splits the block, links the back pointer of the
// next block when split, and marks it used; an allocate that fits nowhere
// visits POOL_BYTES/ALIGN_BYTES blocks. A release stops after the offset check
// for a bad offset, or after the block check for a free block or a non-start;
// a real release merges with free neighbors through the reads and writes of
// the merge steps. The request channel is ready in the cycle after the result
// is loaded. The result sits in an output register and the next item is
// accepted while it waits to be taken; the following result waits until that register is free.
module first_fit_rover_allocator #(
    parameter int POOL_BYTES   = 65536,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 32,
    parameter int GUARD_BYTES  = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ffra_req_if.sink                   i_req,
    ffra_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  logic [ffra_pkg::CFG_W-1:0] i_cfg_wdata
);

    ffra_pkg::t_cmd cmd;
    ffra_pkg::t_sts sts;

    ffra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffra_dpath #(
        .POOL_BYTES   (POOL_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .GUARD_BYTES  (GUARD_BYTES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_type        (i_req.req_type),
        .i_request_bytes   (i_req.request_bytes),
        .i_release_offset  (i_req.release_offset),
        .o_rsp_valid       (o_rsp.valid),
        .i_rsp_ready       (o_rsp.ready),
        .o_payload_offset  (o_rsp.payload_offset),
        .o_status          (o_rsp.status),
        .o_used_bytes      (o_rsp.used_bytes),
        .o_available_bytes (o_rsp.available_bytes)
    );

endmodule

FILE: hw/rtl/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffra_checker #(
    parameter int POOL_BYTES  = 65536,
    parameter int ALIGN_BYTES = 8
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [ffra_pkg::OFF_W-1:0]   i_rsp_payload,
    input logic [ffra_pkg::STAT_W-1:0]  i_rsp_status,
    input logic [ffra_pkg::BYTES_W-1:0] i_rsp_used,
    input logic [ffra_pkg::BYTES_W-1:0] i_rsp_avail
);

    localparam int SPAN = (POOL_BYTES / ALIGN_BYTES) * ALIGN_BYTES;

    `AST_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_payload) && $stable(i_rsp_used), "stalled response changed")
    `AST_IMP(a_sum, i_rsp_valid, ffra_pkg::BYTES_W'(i_rsp_used + i_rsp_avail) == ffra_pkg::BYTES_W'(SPAN), "used plus available is not the pool span")
    `AST_IMP(a_fail_zero, i_rsp_valid && (i_rsp_status != ffra_pkg::ST_OK), i_rsp_payload == '0, "failed request returned an offset")
    `AST_NXT(a_one_item, i_req_valid && i_req_ready, !i_req_ready, "second item taken while one is in work")

endmodule

bind first_fit_rover_allocator ffra_checker #(
    .POOL_BYTES  (POOL_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES)
) u_ffra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload_offset),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_used    (o_rsp.used_bytes),
    .i_rsp_avail   (o_rsp.available_bytes)
);
